// ----- rtl/srpf_pkg.sv -----
// srpf_pkg: shared types and constants of the stepper ramp position follower.
// Depends on nothing; the divider and the follower import it.
`default_nettype none
package srpf_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned SpdMW  = 28;
  localparam int unsigned SpdW   = 17;
  localparam int unsigned TimerHz = 1000000;
  localparam int unsigned PulseHighUs = 10;
  localparam int unsigned DirSetupUs  = 1000;
  localparam int unsigned MilliPerStep = 1000;
  localparam int unsigned DivW   = 26;  // holds 65535 * 1000 and TimerHz + 65535

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_DONE    = 3'd1,
    MODE_SET     = 3'd2,
    MODE_REL     = 3'd3,
    MODE_STOP    = 3'd4,
    MODE_ENABLE  = 3'd5,
    MODE_DISABLE = 3'd6,
    MODE_NONE    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    REG_LIMIT = 3'd0,
    REG_GAIN  = 3'd1,
    REG_MIN   = 3'd2,
    REG_MAX   = 3'd3,
    REG_ACCEL = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_WHOLE,
    ST_DIV,
    ST_OUT
  } state_e;

  // divider handshake
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [SpdW-2:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/srpf_div.sv -----
// srpf_div: restoring divider, one quotient bit per cycle.
// Depends on srpf_pkg.
`default_nettype none
module srpf_div import srpf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [SpdW-2:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DivW:0]   trial;

  // one shift-subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivW-1]} - {{(DivW+1-(SpdW-1)){1'b0}}, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DivW]) begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end else begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

// ----- rtl/stepper_ramp_position_follower.sv -----
// Stepper ramp position follower: event sequencer with a shared divider.
// A plain event goes from idle straight to the result; an enabled tick takes a ramp
// step, then |speed|/1000 on the divider (26 steps), and a pulse-done that re-arms
// takes a period division on the divider (26 steps).
// A new request is taken only after the result of the last one is taken; no overlap.
// Reset (rst_ni low, async): disabled, idle, direction positive, all counts zero,
// registers at their defaults.
`default_nettype none
module stepper_ramp_position_follower import srpf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [22:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         mode_i,
  input  wire logic signed [24:0] step_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    arm_pulse_o,
  output logic [15:0]             pulse_period_us_o,
  output logic [15:0]             pulse_delay_us_o,
  output logic                    step_direction_o,
  output logic                    pulse_cancel_o,
  output logic                    accepted_o,
  output logic signed [23:0]      position_now_o,
  output logic signed [23:0]      target_now_o,
  output logic signed [16:0]      speed_now_sps_o,
  output logic                    pulse_busy_o,
  output logic                    drive_enabled_o,
  output logic [31:0]             tick_count_o
);
  // configuration
  logic [22:0] lim_q;
  logic [9:0]  gain_q;
  logic [15:0] min_q, max_q;
  logic [19:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= 23'd100000;
      gain_q <= 10'd10;
      min_q  <= 16'd50;
      max_q  <= 16'd5000;
      acc_q  <= 20'd20000;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_LIMIT: lim_q  <= cfg_data_i;
        REG_GAIN:  gain_q <= cfg_data_i[9:0];
        REG_MIN:   min_q  <= cfg_data_i[15:0];
        REG_MAX:   max_q  <= cfg_data_i[15:0];
        REG_ACCEL: acc_q  <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // state
  state_e state_q, state_d;
  logic en_q, en_d, run_q, run_d, dirp_q, dirp_d;
  logic signed [PosW-1:0]  pos_q, pos_d, tgt_q, tgt_d;
  logic signed [SpdMW-1:0] spm_q, spm_d;
  logic signed [SpdW-1:0]  spw_q, spw_d;
  logic signed [SpdMW:0]   tgtm_q, tgtm_d;
  logic [31:0] tc_q, tc_d;
  logic arm_q, arm_d, can_q, can_d, acc_d, accp_q;
  logic [15:0] per_q, per_d, dly_q, dly_d;
  div_req_t dreq;
  div_rsp_t drsp;

  srpf_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // event evaluation helpers
  logic signed [PosW:0]   limx, posx, tgtx, err;
  logic signed [PosW+1:0] limw, relsum, newt;
  logic [PosW-1:0]        aerr;
  logic [PosW+9:0]        prod;
  logic [16:0]            tspd;
  logic signed [SpdMW:0]  tgtm, spn, spx;
  logic [SpdMW:0]         aspn;
  logic signed [SpdW-1:0] whole, qs;
  logic [SpdW-1:0]        awhole;
  logic signed [PosW-1:0] pinc;
  logic                   dirok, tsgn, pdir;
  logic [SpdW-2:0]        aspd;
  logic [DivW-1:0]        q;

  function automatic logic allowed(input logic pos_dir, input logic signed [PosW:0] p,
                                   input logic signed [PosW:0] t,
                                   input logic signed [PosW:0] l);
    if (pos_dir) allowed = !(p >= t || p >= l);
    else         allowed = !(p <= t || p <= -l);
  endfunction

  // next state and datapath
  always_comb begin
    state_d = state_q;
    en_d = en_q; run_d = run_q; dirp_d = dirp_q;
    pos_d = pos_q; tgt_d = tgt_q; spm_d = spm_q; spw_d = spw_q; tc_d = tc_q;
    tgtm_d = tgtm_q;
    arm_d = arm_q; can_d = can_q; acc_d = accp_q; per_d = per_q; dly_d = dly_q;
    dreq = '0;
    limx = $signed({2'b00, lim_q});
    limw = $signed({3'b000, lim_q});
    posx = {pos_q[PosW-1], pos_q};
    tgtx = {tgt_q[PosW-1], tgt_q};
    err = tgtx - posx;
    aerr = err[PosW] ? PosW'(-err) : err[PosW-1:0];
    prod = aerr * gain_q;
    tsgn = err[PosW];
    // target speed from the error, minimum tested first
    if (prod < (PosW+10)'(min_q)) tspd = {1'b0, min_q};
    else if (prod > (PosW+10)'(max_q)) tspd = {1'b0, max_q};
    else tspd = prod[16:0];
    if (err == 0 || (spm_q != 0 && spm_q[SpdMW-1] != tsgn)) tgtm = '0;
    else begin
      tgtm = (SpdMW+1)'($signed({12'd0, tspd}) * MilliPerStep);
      if (tsgn) tgtm = -tgtm;
    end
    // ramp toward the registered milli-speed target
    spx = {spm_q[SpdMW-1], spm_q};
    spn = spx;
    if (spx < tgtm_q) begin
      spn = spx + $signed({9'd0, acc_q});
      if (spn > tgtm_q) spn = tgtm_q;
    end else if (spx > tgtm_q) begin
      spn = spx - $signed({9'd0, acc_q});
      if (spn < tgtm_q) spn = tgtm_q;
    end
    aspn = spn[SpdMW] ? (SpdMW+1)'(-spn) : spn;
    q = drsp.quotient;
    // whole steps/s, truncated toward zero
    qs = $signed({1'b0, q[SpdW-2:0]});
    whole = spm_q[SpdMW-1] ? -qs : qs;
    awhole = {1'b0, q[SpdW-2:0]};
    pinc = pos_q + (dirp_q ? PosW'(1) : -PosW'(1));
    relsum = {tgtx[PosW], tgtx} + {step_value_i[24], step_value_i};
    newt = (mode_i == MODE_REL) ? relsum : {step_value_i[24], step_value_i};
    pdir = !spw_q[SpdW-1];
    aspd = spw_q[SpdW-1] ? (SpdW-1)'(-spw_q) : spw_q[SpdW-2:0];
    dirok = 1'b0;

    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        arm_d = 1'b0; can_d = 1'b0; acc_d = 1'b0; per_d = '0; dly_d = '0;
        state_d = ST_OUT;
        unique case (mode_e'(mode_i))
          MODE_TICK: begin
            tc_d = tc_q + 1'b1;
            if (!en_q) begin
              spm_d = '0; spw_d = '0;
            end else begin
              tgtm_d = tgtm;
              state_d = ST_RAMP;
            end
          end
          MODE_DONE: if (run_q) begin
            run_d = 1'b0;
            pos_d = pinc;
            posx = {pinc[PosW-1], pinc};
            if (posx >= limx || posx <= -limx || pinc == tgt_q) begin
              spm_d = '0; spw_d = '0;
            end else if (spw_q != 0 && pdir == dirp_q &&
                         allowed(pdir, posx, tgtx, limx)) begin
              dreq.start = 1'b1;
              dreq.dividend = DivW'(TimerHz) + DivW'(aspd) - 1'b1;
              dreq.divisor = aspd;
              state_d = ST_DIV;
            end
          end
          MODE_SET, MODE_REL: if (en_q && !(mode_i == MODE_REL && step_value_i == 0)
                                  && newt <= limw && newt >= -limw) begin
            tgt_d = newt[PosW-1:0];
            acc_d = 1'b1;
          end
          MODE_STOP: begin
            tgt_d = pos_q; spm_d = '0; spw_d = '0;
          end
          MODE_ENABLE: en_d = 1'b1;
          MODE_DISABLE: begin
            spm_d = '0; spw_d = '0; tgt_d = pos_q;
            can_d = run_q; run_d = 1'b0; en_d = 1'b0;
          end
          default: ;
        endcase
      end
      ST_RAMP: begin
        // new milli-speed, then its magnitude over 1000 on the divider
        spm_d = spn[SpdMW-1:0];
        dreq.start = 1'b1;
        dreq.dividend = aspn[DivW-1:0];
        dreq.divisor = (SpdW-1)'(MilliPerStep);
        state_d = ST_WHOLE;
      end
      ST_WHOLE: if (drsp.done) begin
        spw_d = (awhole < {1'b0, min_q}) ? '0 : whole;
        state_d = ST_OUT;
        // idle drive: first pulse after direction setup
        if (!run_q && spw_d != 0) begin
          dirok = allowed(!spw_d[SpdW-1], posx, tgtx, limx);
          if (!dirok) begin
            spm_d = '0; spw_d = '0;
          end else begin
            dirp_d = !spw_d[SpdW-1];
            arm_d = 1'b1; run_d = 1'b1;
            per_d = 16'(DirSetupUs + PulseHighUs);
            dly_d = 16'(DirSetupUs);
          end
        end
      end
      ST_DIV: if (drsp.done) begin
        // period clamp, delay = period - high time
        arm_d = 1'b1; run_d = 1'b1;
        if (q <= DivW'(PulseHighUs)) per_d = 16'(PulseHighUs + 1);
        else if (q > DivW'(65535)) per_d = 16'hFFFF;
        else per_d = q[15:0];
        dly_d = per_d - 16'(PulseHighUs);
        state_d = ST_OUT;
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      en_q <= 1'b0; run_q <= 1'b0; dirp_q <= 1'b1;
      pos_q <= '0; tgt_q <= '0; spm_q <= '0; spw_q <= '0; tc_q <= '0;
      tgtm_q <= '0;
      arm_q <= 1'b0; can_q <= 1'b0; accp_q <= 1'b0; per_q <= '0; dly_q <= '0;
    end else begin
      state_q <= state_d;
      en_q <= en_d; run_q <= run_d; dirp_q <= dirp_d;
      pos_q <= pos_d; tgt_q <= tgt_d; spm_q <= spm_d; spw_q <= spw_d; tc_q <= tc_d;
      tgtm_q <= tgtm_d;
      arm_q <= arm_d; can_q <= can_d; accp_q <= acc_d; per_q <= per_d; dly_q <= dly_d;
    end
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end

  assign arm_pulse_o       = arm_q;
  assign pulse_period_us_o = per_q;
  assign pulse_delay_us_o  = dly_q;
  assign step_direction_o  = dirp_q;
  assign pulse_cancel_o    = can_q;
  assign accepted_o        = accp_q;
  assign position_now_o    = pos_q;
  assign target_now_o      = tgt_q;
  assign speed_now_sps_o   = spw_q;
  assign pulse_busy_o      = run_q;
  assign drive_enabled_o   = en_q;
  assign tick_count_o      = tc_q;
endmodule
`default_nettype wire

// ----- rtl/srpf_checker.sv -----
// srpf_checker: port-level checks of the follower, bound to the top level.
// Depends on srpf_pkg only through the bound design.
`default_nettype none
module srpf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        arm_pulse_o,
  input wire logic        pulse_busy_o,
  input wire logic        drive_enabled_o,
  input wire logic [15:0] pulse_period_us_o,
  input wire logic [15:0] pulse_delay_us_o
);
  // one request in flight at a time
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during result");

  // result held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

  // arming leaves a running pulse on an enabled drive
  a_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arm_pulse_o |-> pulse_busy_o && drive_enabled_o)
    else $error("arm without busy");

  // delay sits inside the period
  a_dly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arm_pulse_o |-> pulse_delay_us_o < pulse_period_us_o &&
    pulse_delay_us_o != 16'd0) else $error("bad delay");
endmodule

bind stepper_ramp_position_follower srpf_checker u_chk (.*);
`default_nettype wire
